// ===== rtl/psu_pkg.sv =====
`default_nettype none
package psu_pkg;

  // Number of color channels; index 2 is red, 1 green, 0 blue.
  localparam int NUM_CH = 3;
  localparam int CH_W = 8;

  // Input vectors and light direction are signed Q1.14.
  localparam int VEC_W = 16;
  localparam int PROD_W = 2 * VEC_W;
  localparam int DOT_W = PROD_W + 2;
  localparam int FLR_W = DOT_W - 14;
  localparam int SD_W = 2 * FLR_W;
  localparam int S_W = SD_W + 2;

  // Coefficients in [0, 1] as Q.28.
  localparam int FRAC_W = 28;
  localparam int COEF_W = FRAC_W + 1;
  localparam int ONE_Q28 = 1 << FRAC_W;

  // Specular exponent.
  localparam int MAX_SPEC_POWER = 31;
  localparam int SPOW_W = 5;
  localparam int CNT_W = $clog2(MAX_SPEC_POWER + 1);
  localparam int PCMP_W = (CNT_W > SPOW_W) ? CNT_W : SPOW_W;

  // Saturating add: floor(SAT_K * (a + b) / (SAT_K + a * b)).
  localparam int SAT_K = 65025;
  localparam int NUM_W = 25;
  localparam int DEN_W = 17;
  localparam int DIV_ST = 4;
  localparam int SAT_LAT = DIV_ST + 1;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPECULAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z  = 3'd6;

  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/psu_sat_add.sv =====
`default_nettype none
module psu_sat_add (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         valid_i,
  input  wire psu_pkg::rgb_t a_i,
  input  wire psu_pkg::rgb_t b_i,
  output logic              valid_o,
  output psu_pkg::rgb_t     sum_o
);
  import psu_pkg::*;

  logic [DIV_ST:0]                           v_r;
  logic [DIV_ST:0][NUM_CH-1:0][NUM_W-1:0]    rem_r;
  logic [DIV_ST:0][NUM_CH-1:0][DEN_W-1:0]    den_r;
  logic [DIV_ST:0][NUM_CH-1:0][CH_W-1:0]     q_r;
  logic [NUM_CH-1:0][NUM_W-1:0]              num_nxt;
  logic [NUM_CH-1:0][DEN_W-1:0]              den_nxt;

  // Numerator and denominator per channel.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_nxt[c] = NUM_W'(SAT_K) * NUM_W'({1'b0, a_i[c]} + {1'b0, b_i[c]});
      den_nxt[c] = DEN_W'(SAT_K) + DEN_W'(a_i[c]) * DEN_W'(b_i[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_nxt;
      den_r[0] <= den_nxt;
      q_r[0]   <= '0;
    end
  end

  // Restoring division, two quotient bits per stage; the quotient fits 8 bits.
  for (genvar t = 0; t < DIV_ST; t++) begin : g_div
    logic [NUM_CH-1:0][NUM_W-1:0] rem_nxt;
    logic [NUM_CH-1:0][CH_W-1:0]  q_nxt;

    always_comb begin
      logic [NUM_W:0] trial;
      logic [NUM_W:0] dsh;
      int             bpos;
      for (int c = 0; c < NUM_CH; c++) begin
        rem_nxt[c] = rem_r[t][c];
        q_nxt[c]   = q_r[t][c];
        for (int b = 0; b < 2; b++) begin
          bpos  = CH_W - 1 - 2 * t - b;
          dsh   = (NUM_W + 1)'(den_r[t][c]) << bpos;
          trial = {1'b0, rem_nxt[c]} - dsh;
          if (!trial[NUM_W]) begin
            rem_nxt[c] = trial[NUM_W-1:0];
            q_nxt[c]   = q_nxt[c] | (CH_W'(1) << bpos);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[t+1] <= 1'b0;
      end else if (en) begin
        v_r[t+1] <= v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[t+1] <= rem_nxt;
        den_r[t+1] <= den_r[t];
        q_r[t+1]   <= q_nxt;
      end
    end
  end

  assign valid_o = v_r[DIV_ST];

  // The remainder and divisor of the last stage are not needed.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_o[c] = q_r[DIV_ST][c] | CH_W'(rem_r[DIV_ST][c] & '0) | CH_W'(den_r[DIV_ST][c] & '0);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/phong_shading_unit_core.sv =====
`default_nettype none
// Phong shading core: takes one ray hit (unit normal and ray direction, Q1.14)
// per word and returns one shaded RGB word. It accepts a new word every cycle
// while the output is not stalled; each word passes through four dot-product
// and setup stages, 31 specular-power multiply stages, one color scaling
// stage, two five-stage saturating-add dividers and the output register, and
// a stall on the output freezes the whole pipeline. Configuration writes are
// always ready and should only be made while no word is in flight.
module phong_shading_unit_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire psu_pkg::in_word_t                   in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output psu_pkg::out_word_t                       out_word,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import psu_pkg::*;

  logic                    en;
  rgb_t                    amb_col_r, dif_col_r, spc_col_r;
  logic [SPOW_W-1:0]       spow_r;
  logic signed [VEC_W-1:0] lx_r, ly_r, lz_r;
  logic [PCMP_W-1:0]       p_eff;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_col_r <= 24'h0A0A0A;
      dif_col_r <= 24'h3C3C3C;
      spc_col_r <= 24'hFFFFFF;
      spow_r    <= 5'd10;
      lx_r      <= 16'sd13332;
      ly_r      <= -16'sd5714;
      lz_r      <= -16'sd7618;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AMBIENT:  amb_col_r <= cfg_data;
        REG_DIFFUSE:  dif_col_r <= cfg_data;
        REG_SPECULAR: spc_col_r <= cfg_data;
        REG_POWER:    spow_r    <= cfg_data[SPOW_W-1:0];
        REG_LIGHT_X:  lx_r      <= cfg_data[VEC_W-1:0];
        REG_LIGHT_Y:  ly_r      <= cfg_data[VEC_W-1:0];
        REG_LIGHT_Z:  lz_r      <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // The exponent is limited to the number of multiply stages.
  always_comb begin
    if (PCMP_W'(spow_r) > PCMP_W'(MAX_SPEC_POWER)) begin
      p_eff = PCMP_W'(MAX_SPEC_POWER);
    end else begin
      p_eff = PCMP_W'(spow_r);
    end
  end

  // The pipeline moves unless a finished word is held by the consumer.
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Stage A: the nine component products.
  logic                           va_r;
  logic signed [2:0][PROD_W-1:0]  nl_r, dl_r, nd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl_r[0] <= in_word.normal_x * lx_r;
      nl_r[1] <= in_word.normal_y * ly_r;
      nl_r[2] <= in_word.normal_z * lz_r;
      dl_r[0] <= in_word.dir_x * lx_r;
      dl_r[1] <= in_word.dir_y * ly_r;
      dl_r[2] <= in_word.dir_z * lz_r;
      nd_r[0] <= in_word.normal_x * in_word.dir_x;
      nd_r[1] <= in_word.normal_y * in_word.dir_y;
      nd_r[2] <= in_word.normal_z * in_word.dir_z;
    end
  end

  // Stage B: dot products k = -(N.L), L.D and N.D in Q.28.
  logic                    vb_r;
  logic signed [DOT_W-1:0] k_r, ld_r, ndot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r    <= -(DOT_W'($signed(nl_r[0])) + DOT_W'($signed(nl_r[1]))
                  + DOT_W'($signed(nl_r[2])));
      ld_r   <= DOT_W'($signed(dl_r[0])) + DOT_W'($signed(dl_r[1]))
                + DOT_W'($signed(dl_r[2]));
      ndot_r <= DOT_W'($signed(nd_r[0])) + DOT_W'($signed(nd_r[1]))
                + DOT_W'($signed(nd_r[2]));
    end
  end

  // Stage C: floored k times floored N.D, and the clamped diffuse factor.
  logic                    vc_r;
  logic signed [SD_W-1:0]  kd_r;
  logic signed [DOT_W-1:0] ldc_r;
  logic [COEF_W-1:0]       kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kd_r  <= $signed(k_r[DOT_W-1:14]) * $signed(ndot_r[DOT_W-1:14]);
      ldc_r <= ld_r;
      if (k_r > ONE_Q28) begin
        kc_r <= COEF_W'(ONE_Q28);
      end else if (k_r > 0) begin
        kc_r <= k_r[COEF_W-1:0];
      end else begin
        kc_r <= '0;
      end
    end
  end

  // Stage D: specular cosine s, clamped, and the starting power.
  logic                  vd_r;
  logic [COEF_W-1:0]     sc_r, sp0_r, kcd_r;
  logic signed [S_W-1:0] s_val;

  assign s_val = -S_W'(ldc_r) - (S_W'(kd_r) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kcd_r <= kc_r;
      if (s_val > ONE_Q28) begin
        sc_r  <= COEF_W'(ONE_Q28);
        sp0_r <= COEF_W'(ONE_Q28);
      end else if (s_val > 0) begin
        sc_r  <= s_val[COEF_W-1:0];
        sp0_r <= COEF_W'(ONE_Q28);
      end else begin
        sc_r  <= '0;
        sp0_r <= '0;
      end
    end
  end

  // Power chain: stage j multiplies once when j is below the exponent.
  logic [MAX_SPEC_POWER:0]              pw_v;
  logic [MAX_SPEC_POWER:0][COEF_W-1:0]  pw_sp, pw_sc, pw_kc;

  assign pw_v[0]  = vd_r;
  assign pw_sp[0] = sp0_r;
  assign pw_sc[0] = sc_r;
  assign pw_kc[0] = kcd_r;

  for (genvar j = 0; j < MAX_SPEC_POWER; j++) begin : g_pow
    localparam logic [PCMP_W-1:0] STEP = PCMP_W'(j);
    logic                  v_r;
    logic [COEF_W-1:0]     sp_r, scp_r, kcp_r;
    logic [2*COEF_W-1:0]   mul;

    assign mul = pw_sp[j] * pw_sc[j];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= pw_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        scp_r <= pw_sc[j];
        kcp_r <= pw_kc[j];
        if (STEP < p_eff) begin
          sp_r <= mul[FRAC_W +: COEF_W];
        end else begin
          sp_r <= pw_sp[j];
        end
      end
    end

    assign pw_v[j+1]  = v_r;
    assign pw_sp[j+1] = sp_r;
    assign pw_sc[j+1] = scp_r;
    assign pw_kc[j+1] = kcp_r;
  end

  // Stage E: scale the diffuse and specular colors by their factors; ambient passes as is.
  logic ve_r;
  rgb_t amb_r, dif_r, spc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= pw_v[MAX_SPEC_POWER];
    end
  end

  always_ff @(posedge clk) begin
    logic [CH_W+COEF_W-1:0] md;
    logic [CH_W+COEF_W-1:0] ms;
    if (en) begin
      for (int c = 0; c < NUM_CH; c++) begin
        md       = (CH_W + COEF_W)'(dif_col_r[c]) * (CH_W + COEF_W)'(pw_kc[MAX_SPEC_POWER]);
        ms       = (CH_W + COEF_W)'(spc_col_r[c]) * (CH_W + COEF_W)'(pw_sp[MAX_SPEC_POWER]);
        dif_r[c] <= md[FRAC_W +: CH_W];
        spc_r[c] <= ms[FRAC_W +: CH_W];
        amb_r[c] <= amb_col_r[c];
      end
    end
  end

  // Ambient plus diffuse, with the specular term delayed alongside.
  logic                    v1;
  rgb_t                    sum1;
  rgb_t [SAT_LAT-1:0]      spc_dly_r;

  psu_sat_add u_add1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (ve_r),
    .a_i     (amb_r),
    .b_i     (dif_r),
    .valid_o (v1),
    .sum_o   (sum1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      spc_dly_r <= {spc_dly_r[SAT_LAT-2:0], spc_r};
    end
  end

  // Then the specular term.
  logic v2;
  rgb_t sum2;

  psu_sat_add u_add2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (v1),
    .a_i     (sum1),
    .b_i     (spc_dly_r[SAT_LAT-1]),
    .valid_o (v2),
    .sum_o   (sum2)
  );

  // Output register.
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.red   <= sum2[2];
      out_word_r.green <= sum2[1];
      out_word_r.blue  <= sum2[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ===== dv/phong_shading_unit_core_test.sv =====
`default_nettype none
module phong_shading_unit_core_test;
  import psu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH = 47;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint ONE_FIX = 64'sd1 << 28;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  phong_shading_unit_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Material and light settings as the shader should currently hold them.
  logic [23:0] amb_rgb, dif_rgb, spec_rgb;
  logic [4:0] spec_pow;
  logic signed [15:0] lgt_x, lgt_y, lgt_z;

  in_word_t hit_queue[$];
  out_word_t shade_queue[$];
  int errors;
  longint cycles;
  bit feeding;
  int burst_left, gap_left;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // The run ends in failure if it takes far longer than expected.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint floor14(longint x);
    return x >>> 14;
  endfunction

  function automatic int unsigned blend(int unsigned a, int unsigned b);
    longint unsigned num, den;
    num = 64'd65025 * (a + b);
    den = 64'd65025 + a * b;
    return 32'(num / den);
  endfunction

  // Compute the shaded color of one hit under the current settings.
  function automatic out_word_t shade_hit(in_word_t h);
    longint nx, ny, nz, dx, dy, dz, lx, ly, lz, kd, ld, nd, sv, kc, sp, sc;
    int unsigned a, d, s;
    out_word_t r;
    logic [7:0] px[3];
    nx = h.normal_x; ny = h.normal_y; nz = h.normal_z;
    dx = h.dir_x; dy = h.dir_y; dz = h.dir_z;
    lx = lgt_x; ly = lgt_y; lz = lgt_z;
    kd = -(nx * lx + ny * ly + nz * lz);
    ld = dx * lx + dy * ly + dz * lz;
    nd = nx * dx + ny * dy + nz * dz;
    sv = -ld - 2 * floor14(kd) * floor14(nd);
    kc = 0;
    sp = 0;
    if (kd > 0) kc = (kd > ONE_FIX) ? ONE_FIX : kd;
    if (sv > 0) begin
      sc = (sv > ONE_FIX) ? ONE_FIX : sv;
      sp = ONE_FIX;
      for (int i = 0; i < spec_pow; i++) sp = (sp * sc) >>> 28;
    end
    for (int ch = 0; ch < 3; ch++) begin
      a = 32'((amb_rgb >> (16 - 8 * ch)) & 8'hFF);
      d = 32'((((dif_rgb >> (16 - 8 * ch)) & 8'hFF) * kc) >>> 28);
      s = 32'((((spec_rgb >> (16 - 8 * ch)) & 8'hFF) * sp) >>> 28);
      px[ch] = 8'(blend(blend(a, d), s));
    end
    r.red = px[0];
    r.green = px[1];
    r.blue = px[2];
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Driver: bursts of words with random gaps; the payload holds while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) shade_queue.insert(shade_queue.size(), shade_hit(in_word));
      if (hit_queue.size() != 0 && feeding && gap_left == 0) begin
        in_word <= hit_queue.pop_front();
        in_valid <= 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Monitor: the receiver stalls in phases of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shade_queue.size() == 0) begin
          report("unexpected word", int'(out_word), 0);
        end else begin
          out_word_t e;
          e = shade_queue.pop_front();
          if (out_word.red !== e.red) report("red", out_word.red, e.red);
          if (out_word.green !== e.green) report("green", out_word.green, e.green);
          if (out_word.blue !== e.blue) report("blue", out_word.blue, e.blue);
        end
      end
      if (cycles % 512 < 128) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // One register write, after which the port is left idle before the task returns.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_AMBIENT: amb_rgb = val;
      REG_DIFFUSE: dif_rgb = val;
      REG_SPECULAR: spec_rgb = val;
      REG_POWER: spec_pow = val[4:0];
      REG_LIGHT_X: lgt_x = val[15:0];
      REG_LIGHT_Y: lgt_y = val[15:0];
      REG_LIGHT_Z: lgt_z = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_q14();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Random vector close to unit length, with a random sign on each axis.
  task automatic unit_vec(output logic signed [15:0] x, y, z);
    int a, b, c;
    real n;
    a = $urandom_range(0, 2000) - 1000;
    b = $urandom_range(0, 2000) - 1000;
    c = $urandom_range(0, 2000) - 1000;
    if (a == 0 && b == 0 && c == 0) a = 1;
    n = $sqrt(real'(a * a + b * b + c * c));
    x = 16'($rtoi(16384.0 * a / n));
    y = 16'($rtoi(16384.0 * b / n));
    z = 16'($rtoi(16384.0 * c / n));
  endtask

  task automatic add_hit(logic signed [15:0] a, b, c, d, e, f);
    in_word_t w;
    w.normal_x = a; w.normal_y = b; w.normal_z = c;
    w.dir_x = d; w.dir_y = e; w.dir_z = f;
    hit_queue.insert(hit_queue.size(), w);
  endtask

  task automatic add_random_hits(int n);
    logic signed [15:0] a, b, c, d, e, f;
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) begin
        unit_vec(a, b, c);
        unit_vec(d, e, f);
        add_hit(a, b, c, d, e, f);
      end else begin
        add_hit(rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14());
      end
    end
  endtask

  // Let all queued words pass, then wait out the pipeline before a write.
  task automatic drain();
    feeding = 1;
    while (hit_queue.size() != 0 || in_valid || shade_queue.size() != 0) @(posedge clk);
    feeding = 0;
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] a, b, c;
    errors = 0;
    cycles = 0;
    feeding = 0;
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    amb_rgb = 24'h0A0A0A;
    dif_rgb = 24'h3C3C3C;
    spec_rgb = 24'hFFFFFF;
    spec_pow = 5'd10;
    lgt_x = 16'sd13332;
    lgt_y = -16'sd5714;
    lgt_z = -16'sd7618;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed hits: facing and opposing the light, axis extremes, grazing.
    add_hit(-16'sd13332, 16'sd5714, 16'sd7618, 16'sd13332, -16'sd5714, -16'sd7618);
    add_hit(16'sd13332, -16'sd5714, -16'sd7618, 16'sd13332, -16'sd5714, -16'sd7618);
    add_hit(-16'sd13332, 16'sd5714, 16'sd7618, -16'sd13332, 16'sd5714, 16'sd7618);
    add_hit(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
    add_hit(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    add_hit(-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384);
    add_hit(0, 0, 0, 0, 0, 0);
    add_hit(0, 0, 16'sd16384, 0, 0, -16'sd16384);
    add_hit(16'sd16384, 0, 0, 0, 16'sd16384, 0);
    add_hit(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    add_hit(16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF);
    add_random_hits(8);
    drain();

    // Several settings, including both extremes of the ambient, specular and power registers.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_AMBIENT, 24'h000000);
          write_reg(REG_DIFFUSE, 24'hFFFFFF);
          write_reg(REG_SPECULAR, 24'h000000);
          write_reg(REG_POWER, 24'd0);
        end
        1: begin
          write_reg(REG_AMBIENT, 24'hFFFFFF);
          write_reg(REG_SPECULAR, 24'hFFFFFF);
          write_reg(REG_POWER, 24'd31);
        end
        2: begin
          write_reg(REG_LIGHT_X, 24'h004000);
          write_reg(REG_LIGHT_Y, 24'h000000);
          write_reg(REG_LIGHT_Z, 24'h000000);
          write_reg(REG_POWER, 24'd1);
        end
        3: begin
          write_reg(REG_LIGHT_X, 24'hFFC000);
          write_reg(REG_LIGHT_Y, 24'h008000);
          write_reg(REG_LIGHT_Z, 24'h007FFF);
          write_reg(REG_UNUSED, 24'h123456);
        end
        default: begin
          unit_vec(a, b, c);
          write_reg(REG_LIGHT_X, 24'(a));
          write_reg(REG_LIGHT_Y, 24'(b));
          write_reg(REG_LIGHT_Z, 24'(c));
          write_reg(REG_AMBIENT, 24'($urandom_range(0, 24'hFFFFFF)));
          write_reg(REG_DIFFUSE, 24'($urandom_range(0, 24'hFFFFFF)));
          write_reg(REG_SPECULAR, 24'($urandom_range(0, 24'hFFFFFF)));
          write_reg(REG_POWER, 24'($urandom_range(0, 31)));
        end
      endcase
      add_random_hits(100);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
